// ----- hw/rtl/clock_page_replacer_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the clock page replacer.
// ---------------------------------------------------------------------------
`ifndef CLOCK_PAGE_REPLACER_DEFINES_SVH
`define CLOCK_PAGE_REPLACER_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge outside reset.
`define CPR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every rising edge, reset included.
`define CPR_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define CPR_ASSERT(name, prop, msg)
`define CPR_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// ----- hw/rtl/cpr_pkg.sv -----
// ---------------------------------------------------------------------------
// cpr_pkg
// Types and constants shared by the clock page replacer.
// ---------------------------------------------------------------------------
package cpr_pkg;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned FRAME_W = 8;
  localparam int unsigned CFG_W   = 9;
  localparam int unsigned COUNT_W = 9;
  // Sweep step counter; it must hold twice the largest active pool size.
  localparam int unsigned STEP_W  = CFG_W + 1;

  typedef enum logic [FUNC_W-1:0] {
    FN_PIN    = 2'd0,
    FN_UNPIN  = 2'd1,
    FN_VICTIM = 2'd2,
    FN_STATUS = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_ABSENT = 2'd0,
    ST_CLEAR  = 2'd1,
    ST_SET    = 2'd2
  } status_e;

endpackage

// ----- hw/rtl/clock_page_replacer.sv -----
// ---------------------------------------------------------------------------
// clock_page_replacer
// Second-chance (clock) replacer over a pool of frames.
// ---------------------------------------------------------------------------
// The input channel (in_valid_i / in_stall_o) takes one command item: pin,
// unpin, pick victim or status. Each item gives exactly one result item on
// the output channel (out_valid_o / out_stall_i) with the victim flag, the
// victim frame and the present count after the command.
// The frame states live in a single-port status memory with a registered
// read; pins and unpins inside the pool and victim sweeps read-modify-write
// that memory. Status and ignored commands finish in the accept cycle and
// their result goes to the output register, or to the hold register while
// the output is stalled. Pin and unpin read in the accept cycle and write in
// S_RMW. A victim request reads and evaluates each frame it visits, for two passes at most.
// The block takes a new item only after the previous one has finished. A
// finished result waits in the output register while the next item is
// accepted; if that register is still stalled when the next result is
// ready, the block holds the result and stalls its input.
// After reset the status memory is cleared one entry per cycle; the input is
// stalled during that pass. The user must write the frame count register
// through cfg_we_i / cfg_wdata_i only while no item is in flight; the block
// itself does not enforce this.
// ---------------------------------------------------------------------------
`include "clock_page_replacer_defines.svh"

module clock_page_replacer #(
  parameter int unsigned MAX_FRAMES = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cpr_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [cpr_pkg::FUNC_W-1:0]  func_i,
  input  logic [cpr_pkg::FRAME_W-1:0] frame_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        victim_found_o,
  output logic [cpr_pkg::FRAME_W-1:0] victim_frame_o,
  output logic [cpr_pkg::COUNT_W-1:0] present_count_o
);
  import cpr_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_FRAMES);
  localparam int unsigned CW    = (AW > CFG_W) ? AW : CFG_W;
  localparam int unsigned N_RST = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_FRAMES - 1);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_RMW,
    S_RD,
    S_EVAL,
    S_HOLD
  } state_e;

  state_e               state_q, state_d;
  logic [AW-1:0]        clr_q, clr_d;
  logic [CFG_W-1:0]     n_q, n_d;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic [AW-1:0]        hand_q, hand_d;
  logic [AW-1:0]        ptr_q, ptr_d;
  logic [STEP_W-1:0]    steps_q, steps_d;
  func_e                func_q, func_d;
  logic [FRAME_W-1:0]   frame_q, frame_d;
  logic                 res_found_q, res_found_d;
  logic [AW-1:0]        res_frame_q, res_frame_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_found_q, out_found_d;
  logic [FRAME_W-1:0]   out_frame_q, out_frame_d;
  logic [COUNT_W-1:0]   out_count_q, out_count_d;

  status_e              status_mem [MAX_FRAMES];
  status_e              rdata_q;
  logic                 mem_re, mem_we;
  logic [AW-1:0]        mem_raddr, mem_waddr;
  status_e              mem_wdata;

  logic                 done, done_found;
  logic [AW-1:0]        done_frame;
  logic                 out_free;
  logic [AW-1:0]        start_ptr, ptr_next;
  logic [CW-1:0]        ptr_inc;
  logic                 frame_in_pool;

  // A shrunk pool can leave the hand past its end; the sweep then starts at 0.
  assign start_ptr     = (CW'(hand_q) >= CW'(n_q)) ? '0 : hand_q;
  assign ptr_inc       = CW'(ptr_q) + CW'(1);
  assign ptr_next      = (ptr_inc >= CW'(n_q)) ? '0 : AW'(ptr_inc);
  assign frame_in_pool = ({1'b0, frame_i} < n_q);
  assign out_free      = !(out_valid_q && out_stall_i);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    n_d         = n_q;
    count_d     = count_q;
    hand_d      = hand_q;
    ptr_d       = ptr_q;
    steps_d     = steps_q;
    func_d      = func_q;
    frame_d     = frame_q;
    res_found_d = res_found_q;
    res_frame_d = res_frame_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_found_d = out_found_q;
    out_frame_d = out_frame_q;
    out_count_d = out_count_q;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = ST_ABSENT;
    done        = 1'b0;
    done_found  = 1'b0;
    done_frame  = '0;

    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        n_d = CFG_W'(1);
      end else if (32'(cfg_wdata_i) > MAX_FRAMES) begin
        n_d = CFG_W'(MAX_FRAMES);
      end else begin
        n_d = cfg_wdata_i;
      end
    end

    case (state_q)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + AW'(1);
        if (clr_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          func_d  = func_e'(func_i);
          frame_d = frame_i;
          case (func_e'(func_i))
            FN_PIN, FN_UNPIN: begin
              if (frame_in_pool) begin
                mem_re    = 1'b1;
                mem_raddr = AW'(frame_i);
                state_d   = S_RMW;
              end else begin
                done = 1'b1;
              end
            end
            FN_VICTIM: begin
              if (count_q == '0) begin
                done = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = start_ptr;
                ptr_d     = start_ptr;
                steps_d   = '0;
                state_d   = S_EVAL;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      S_RMW: begin
        mem_waddr = AW'(frame_q);
        if (func_q == FN_PIN) begin
          if (rdata_q != ST_ABSENT) begin
            mem_we    = 1'b1;
            mem_wdata = ST_ABSENT;
            if (count_q != '0) begin
              count_d = count_q - COUNT_W'(1);
            end
          end
        end else if (rdata_q == ST_ABSENT) begin
          mem_we    = 1'b1;
          mem_wdata = ST_SET;
          count_d   = count_q + COUNT_W'(1);
        end
        done = 1'b1;
      end
      S_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ptr_q;
        state_d   = S_EVAL;
      end
      S_EVAL: begin
        mem_waddr = ptr_q;
        if (rdata_q == ST_CLEAR) begin
          mem_we     = 1'b1;
          mem_wdata  = ST_ABSENT;
          count_d    = count_q - COUNT_W'(1);
          hand_d     = ptr_next;
          done       = 1'b1;
          done_found = 1'b1;
          done_frame = ptr_q;
        end else begin
          if (rdata_q == ST_SET) begin
            mem_we    = 1'b1;
            mem_wdata = ST_CLEAR;
          end
          // Two full passes without a clear frame means nothing evictable
          // lies inside the active range.
          if (steps_q + STEP_W'(1) == {n_q, 1'b0}) begin
            done = 1'b1;
          end else begin
            ptr_d   = ptr_next;
            steps_d = steps_q + STEP_W'(1);
            state_d = S_RD;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_found_d = res_found_q;
          out_frame_d = FRAME_W'(res_frame_q);
          out_count_d = count_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (done) begin
      if (out_free) begin
        out_valid_d = 1'b1;
        out_found_d = done_found;
        out_frame_d = FRAME_W'(done_frame);
        out_count_d = count_d;
        state_d     = S_IDLE;
      end else begin
        res_found_d = done_found;
        res_frame_d = done_frame;
        state_d     = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      n_q         <= CFG_W'(N_RST);
      count_q     <= '0;
      hand_q      <= '0;
      ptr_q       <= '0;
      steps_q     <= '0;
      func_q      <= FN_STATUS;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      n_q         <= n_d;
      count_q     <= count_d;
      hand_q      <= hand_d;
      ptr_q       <= ptr_d;
      steps_q     <= steps_d;
      func_q      <= func_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q     <= frame_d;
    res_found_q <= res_found_d;
    res_frame_q <= res_frame_d;
    out_found_q <= out_found_d;
    out_frame_q <= out_frame_d;
    out_count_q <= out_count_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      status_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= status_mem[mem_raddr];
    end
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign victim_found_o  = out_found_q;
  assign victim_frame_o  = out_frame_q;
  assign present_count_o = out_count_q;

  `CPR_ASSERT(a_hold_needs_busy_out, (state_q == S_HOLD) |-> out_valid_q, "held result with free output")
  `CPR_ASSERT(a_evict_drops_count, (state_q == S_EVAL && rdata_q == ST_CLEAR) |=> (count_q == $past(count_q) - COUNT_W'(1)), "eviction did not lower the count")
  `CPR_ASSERT(a_sweep_bounded, (state_q == S_EVAL) |-> (steps_q < {n_q, 1'b0}), "sweep ran past two passes")
  `CPR_ASSERT_ALWAYS(a_no_accept_in_clear, (state_q == S_CLR) |-> in_stall_o, "item accepted during clearing pass")

endmodule

// ----- bench/tb_clock_page_replacer.sv -----
// ---------------------------------------------------------------------------
// tb_clock_page_replacer
// Self-checking bench for the second-chance clock replacer. A directed list
// covers the empty pool, edge frame numbers, out-of-range pool sizes, a
// shrink past the hand and a sweep that gives up. Random phases then run
// with random pool sizes. Every result item is checked against a model of
// the frame states, hand and present count kept in the bench, or against a typed result.
// ---------------------------------------------------------------------------
module tb_clock_page_replacer;
  timeunit 1ns;
  timeprecision 1ps;

  import cpr_pkg::*;

  localparam int unsigned POOL_MAX = 256;
  localparam int RANDOM_ITEMS = 450;
  localparam int DIR_ROWS = 27;

  typedef struct packed {
    logic               found;
    logic [FRAME_W-1:0] frame;
    logic [COUNT_W-1:0] count;
  } cmd_result_t;

  // One directed step: either a pool size write or a command item, with the
  // result typed in where it is obvious.
  typedef struct packed {
    logic               is_cfg;
    func_e              op;
    logic [FRAME_W-1:0] frame_no;
    logic [CFG_W-1:0]   pool;
    logic               typed;
    cmd_result_t        res;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [FUNC_W-1:0]  func_in = FN_STATUS;
  logic [FRAME_W-1:0] frame_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               victim_found;
  logic [FRAME_W-1:0] victim_frame;
  logic [COUNT_W-1:0] present_count;

  // Bench copy of the replacer state.
  status_e            frame_state [POOL_MAX];
  logic [FRAME_W-1:0] sweep_hand;
  logic [COUNT_W-1:0] present_frames;
  logic [CFG_W-1:0]   pool_cfg;

  cmd_result_t        pending_results [$];
  int                 mismatch_count = 0;
  int                 hold_cycles = 0;
  bit                 quiet_send = 1'b0;
  bit                 quiet_recv = 1'b0;
  int                 func_tally [4] = '{0, 0, 0, 0};
  int                 evictions = 0;
  int                 cfg_writes = 0;

  dir_row_t directed_rows [DIR_ROWS] = '{
    // Fresh pool: nothing is tracked and a victim request finds nothing.
    '{1'b0, FN_STATUS, 8'd255, 9'd0, 1'b1, '{1'b0, 8'd0, 9'd0}},
    '{1'b0, FN_VICTIM, 8'd0,   9'd0, 1'b1, '{1'b0, 8'd0, 9'd0}},
    '{1'b0, FN_PIN,    8'd5,   9'd0, 1'b1, '{1'b0, 8'd0, 9'd0}},
    '{1'b0, FN_UNPIN,  8'd0,   9'd0, 1'b1, '{1'b0, 8'd0, 9'd1}},
    '{1'b0, FN_UNPIN,  8'd255, 9'd0, 1'b1, '{1'b0, 8'd0, 9'd2}},
    '{1'b0, FN_UNPIN,  8'd255, 9'd0, 1'b1, '{1'b0, 8'd0, 9'd2}},
    '{1'b0, FN_VICTIM, 8'd0,   9'd0, 1'b0, '0},
    '{1'b0, FN_UNPIN,  8'd7,   9'd0, 1'b0, '0},
    '{1'b0, FN_PIN,    8'd255, 9'd0, 1'b0, '0},
    '{1'b0, FN_VICTIM, 8'd0,   9'd0, 1'b0, '0},
    // A size of zero acts as a one-frame pool, and the hand is now past it.
    '{1'b1, FN_STATUS, 8'd0,   9'd0, 1'b0, '0},
    '{1'b0, FN_UNPIN,  8'd200, 9'd0, 1'b0, '0},
    '{1'b0, FN_PIN,    8'd7,   9'd0, 1'b0, '0},
    '{1'b0, FN_UNPIN,  8'd0,   9'd0, 1'b0, '0},
    '{1'b0, FN_VICTIM, 8'd0,   9'd0, 1'b0, '0},
    // Sizes above the pool act as the full pool.
    '{1'b1, FN_STATUS, 8'd0,   9'd511, 1'b0, '0},
    '{1'b0, FN_UNPIN,  8'd128, 9'd0, 1'b0, '0},
    '{1'b0, FN_UNPIN,  8'd2,   9'd0, 1'b0, '0},
    '{1'b0, FN_VICTIM, 8'd0,   9'd0, 1'b0, '0},
    // Shrink so that the only present frame lies outside the active range.
    '{1'b1, FN_STATUS, 8'd0,   9'd4, 1'b0, '0},
    '{1'b0, FN_PIN,    8'd128, 9'd0, 1'b0, '0},
    '{1'b0, FN_VICTIM, 8'd0,   9'd0, 1'b0, '0},
    '{1'b0, FN_UNPIN,  8'd3,   9'd0, 1'b0, '0},
    '{1'b0, FN_VICTIM, 8'd0,   9'd0, 1'b0, '0},
    '{1'b1, FN_STATUS, 8'd0,   9'd256, 1'b0, '0},
    '{1'b0, FN_PIN,    8'd128, 9'd0, 1'b0, '0},
    '{1'b0, FN_STATUS, 8'd170, 9'd0, 1'b0, '0}
  };

  clock_page_replacer #(
    .MAX_FRAMES(POOL_MAX)
  ) u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .func_i         (func_in),
    .frame_i        (frame_in),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .victim_found_o (victim_found),
    .victim_frame_o (victim_frame),
    .present_count_o(present_count)
  );

  always #6 clk = ~clk;

  initial begin
    #60ms;
    $display("simulation failed");
    $finish;
  end

  function automatic int active_frames();
    if (pool_cfg == 0) return 1;
    if (pool_cfg > POOL_MAX) return POOL_MAX;
    return int'(pool_cfg);
  endfunction

  // Applies one command to the bench state and returns the result it gives.
  function automatic cmd_result_t predict_command(input func_e op,
                                                  input logic [FRAME_W-1:0] fr);
    int n;
    int h;
    cmd_result_t r;
    n = active_frames();
    r = '0;
    case (op)
      FN_PIN: begin
        if (fr < n && frame_state[fr] != ST_ABSENT) begin
          frame_state[fr] = ST_ABSENT;
          if (present_frames != 0) present_frames--;
        end
      end
      FN_UNPIN: begin
        if (fr < n && frame_state[fr] == ST_ABSENT) begin
          frame_state[fr] = ST_SET;
          present_frames++;
        end
      end
      FN_VICTIM: begin
        if (present_frames != 0) begin
          h = (sweep_hand >= n) ? 0 : int'(sweep_hand);
          // Two passes at most: the first may only clear reference bits.
          for (int steps = 0; steps < 2 * n && !r.found; steps++) begin
            if (frame_state[h] == ST_CLEAR) begin
              frame_state[h] = ST_ABSENT;
              present_frames--;
              r.found = 1'b1;
              r.frame = h[FRAME_W-1:0];
            end else if (frame_state[h] == ST_SET) begin
              frame_state[h] = ST_CLEAR;
            end
            h = (h + 1 >= n) ? 0 : h + 1;
          end
          if (r.found) sweep_hand = h[FRAME_W-1:0];
        end
      end
      default: ;
    endcase
    r.count = present_frames;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Result side: check each accepted item and draw the stall before the next.
  always @(posedge clk) begin : result_check
    cmd_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with none pending: found=%0b frame=%0d count=%0d",
                                  victim_found, victim_frame, present_count));
      end else begin
        want = pending_results.pop_front();
        if (victim_found !== want.found)
          report_mismatch($sformatf("victim_found %0b, want %0b", victim_found, want.found));
        if (victim_frame !== want.frame)
          report_mismatch($sformatf("victim_frame %0d, want %0d", victim_frame, want.frame));
        if (present_count !== want.count)
          report_mismatch($sformatf("present_count %0d, want %0d", present_count, want.count));
      end
      hold_cycles = quiet_recv ? 0 : $urandom_range(11);
    end else if (hold_cycles != 0) begin
      hold_cycles--;
    end
  end

  always @(negedge clk) begin
    out_stall = (hold_cycles != 0);
  end

  // Returns at a falling edge with the input channel idle and nothing pending.
  task automatic wait_all_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_pool_size(input logic [CFG_W-1:0] value);
    wait_all_results();
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(posedge clk);
    pool_cfg = value;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_writes++;
  endtask

  task automatic send_command(input func_e op, input logic [FRAME_W-1:0] fr,
                              input bit typed, input cmd_result_t typed_res);
    int gap;
    cmd_result_t want;
    gap = quiet_send ? 0 : $urandom_range(11);
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    func_in = op;
    frame_in = fr;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    want = predict_command(op, fr);
    if (typed) want = typed_res;
    pending_results.push_back(want);
    func_tally[op]++;
    if (want.found) evictions++;
  endtask

  initial begin : stimulus
    int random_items;
    int phase_len;
    int pick;
    int n;
    logic [CFG_W-1:0] size_pick;
    logic [FRAME_W-1:0] fr;
    func_e op;

    random_items = 0;
    for (int i = 0; i < POOL_MAX; i++) frame_state[i] = ST_ABSENT;
    sweep_hand = '0;
    present_frames = '0;
    pool_cfg = 9'd256;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (directed_rows[i].is_cfg)
        write_pool_size(directed_rows[i].pool);
      else
        send_command(directed_rows[i].op, directed_rows[i].frame_no,
                     directed_rows[i].typed, directed_rows[i].res);
    end

    // Random phases; small pools dominate since full-pool sweeps are slow.
    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 8) size_pick = 9'd0;
      else if (pick < 14) size_pick = 9'd1;
      else if (pick < 20) size_pick = 9'd256;
      else if (pick < 24) size_pick = 9'd511;
      else if (pick < 30) size_pick = CFG_W'($urandom_range(257, 511));
      else if (pick < 42) size_pick = CFG_W'($urandom_range(65, 255));
      else if (pick < 60) size_pick = CFG_W'($urandom_range(17, 64));
      else size_pick = CFG_W'($urandom_range(2, 16));
      write_pool_size(size_pick);
      quiet_send = ($urandom_range(3) == 0);
      quiet_recv = ($urandom_range(3) == 0);
      n = active_frames();
      phase_len = (n > 64) ? $urandom_range(8, 20) : $urandom_range(15, 45);
      for (int k = 0; k < phase_len; k++) begin
        pick = $urandom_range(99);
        if (pick < 20) op = FN_PIN;
        else if (pick < 60) op = FN_UNPIN;
        else if (pick < 85) op = FN_VICTIM;
        else op = FN_STATUS;
        if ($urandom_range(99) < 85) fr = FRAME_W'($urandom_range(n - 1));
        else fr = FRAME_W'($urandom_range(255));
        // Now and then let the block run dry before the next item.
        if ($urandom_range(49) == 0) wait_all_results();
        send_command(op, fr, 1'b0, '0);
        random_items++;
      end
    end

    wait_all_results();
    repeat (64) @(posedge clk);

    $display("Ran %0d pin, %0d unpin, %0d victim and %0d status items; %0d frames evicted.",
             func_tally[FN_PIN], func_tally[FN_UNPIN], func_tally[FN_VICTIM],
             func_tally[FN_STATUS], evictions);
    $display("Pool size written %0d times; %0d mismatches seen.", cfg_writes, mismatch_count);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
